[hw/rtl/tour_swap_hill_climb_unit_assert.svh]
// assertion macros shared by the checker of the tour swap unit
// depends on nothing; the including module supplies clk and arst_n
`ifndef TOUR_SWAP_HILL_CLIMB_UNIT_ASSERT_SVH
`define TOUR_SWAP_HILL_CLIMB_UNIT_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define TSHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition must hold at every edge outside reset
`define TSHC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

[hw/rtl/tshc_pkg.sv]
// shared types and constants of the tour swap hill climbing unit
// depends on nothing
package tshc_pkg;

	localparam int MAX_CITIES = 128;
	localparam int COORD_BITS = 10;
	localparam int IDX_W      = 7;
	localparam int CNT_W      = 8;
	localparam int ENT_W      = 2 * COORD_BITS;
	localparam int SQ_W       = 2 * COORD_BITS + 1;
	localparam int RAD_W      = 38;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int SUM_W      = 27;
	localparam int LEN_W      = 18;
	localparam int CNT_RESET  = 100;

	typedef enum logic [1:0] {
		STAT_LOADED  = 2'd0,
		STAT_KEPT    = 2'd1,
		STAT_UNDONE  = 2'd2,
		STAT_INVALID = 2'd3
	} status_t;

	typedef struct packed {
		logic             mode;
		logic [IDX_W-1:0] first_city;
		logic [IDX_W-1:0] second_city;
		logic [9:0]       coord_x;
		logic [9:0]       coord_y;
	} in_item_t;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] path_length;
	} out_item_t;

	typedef enum logic [3:0] {
		FSM_IDLE,
		FSM_LOAD,
		FSM_P_RD,
		FSM_P_DAT,
		FSM_P_SQ,
		FSM_P_RT,
		FSM_P_END,
		FSM_SW_RA,
		FSM_SW_RB,
		FSM_SW_WA,
		FSM_SW_WB,
		FSM_UN_A,
		FSM_UN_B,
		FSM_OUT
	} fsm_t;

endpackage

[hw/rtl/tour_swap_hill_climb_unit.sv]
// Top level of the tour swap hill climbing unit: coordinate store, path length sequencer.
// Depends on tshc_pkg.
// Every transaction is followed by a full open-path length pass over the coordinate
// store: per edge, FSM_P_RD issues the read, FSM_P_DAT takes the difference, FSM_P_SQ forms
// the squares and FSM_P_RT runs a bit-serial square root. A load writes one entry and then
// runs one pass. A legal swap runs a pass, exchanges the two entries through the single
// memory write port, runs a second pass and, if the whole part grew, writes the entries
// back. The input is stalled while an item is in work; the result sits in an output
// register so the next item can be taken while it waits.
module tour_swap_hill_climb_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  tshc_pkg::in_item_t     in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output tshc_pkg::out_item_t    out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [7:0]             cfg_data
);
	import tshc_pkg::*;

	fsm_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_w;
	in_item_t          op_q;
	logic              pass_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ENT_W-1:0]  prev_q;
	logic [COORD_BITS-1:0] dx_q, dy_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0]        bit_cnt_q;
	logic [SUM_W-1:0]  sum_q, before_q, res_sum_q;
	status_t           res_status_q;
	logic [ENT_W-1:0]  ent_a_q, ent_b_q;
	logic              out_valid_q;
	out_item_t         out_q;

	// coordinate store, {x, y} per entry
	logic [ENT_W-1:0]  mem [MAX_CITIES];
	logic [ENT_W-1:0]  rdata_q;
	logic              we;
	logic [IDX_W-1:0]  waddr, raddr;
	logic [ENT_W-1:0]  wdata;

	logic              accept;
	logic              swap_ok;
	logic              last_edge;
	logic              grew;
	logic [COORD_BITS:0] diff_x, diff_y;
	logic [SQ_W-1:0]   sq_sum;
	logic [REM_W-1:0]  rem_sh, trial, rem_n;
	logic [ROOT_W-1:0] root_n;
	logic [SUM_W-9:0]  whole;

	assign n_w = (count_q > CNT_W'(MAX_CITIES)) ? CNT_W'(MAX_CITIES) : count_q;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != FSM_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign swap_ok = (in_data.first_city != in_data.second_city)
		&& ({1'b0, in_data.first_city} < n_w) && ({1'b0, in_data.second_city} < n_w);
	assign last_edge = ({1'b0, idx_q} == (n_w - CNT_W'(1)));
	assign grew = (sum_q[SUM_W-1:8] > before_q[SUM_W-1:8]);

	// edge difference; its magnitude is taken when it is registered
	assign diff_x = {1'b0, rdata_q[ENT_W-1:COORD_BITS]} - {1'b0, prev_q[ENT_W-1:COORD_BITS]};
	assign diff_y = {1'b0, rdata_q[COORD_BITS-1:0]} - {1'b0, prev_q[COORD_BITS-1:0]};
	assign sq_sum = SQ_W'(dx_q) * SQ_W'(dx_q) + SQ_W'(dy_q) * SQ_W'(dy_q);

	// one restoring square root step
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
	assign trial  = {1'b0, root_q, 2'b01};
	always_comb begin
		if (rem_sh >= trial) begin
			rem_n  = rem_sh - trial;
			root_n = {root_q[ROOT_W-2:0], 1'b1};
		end else begin
			rem_n  = rem_sh;
			root_n = {root_q[ROOT_W-2:0], 1'b0};
		end
	end

	assign whole = res_sum_q[SUM_W-1:8];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = op_q.first_city;
		wdata   = rdata_q;
		raddr   = idx_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					if (!in_data.mode) begin
						state_d = FSM_LOAD;
					end else begin
						state_d = FSM_P_RD;
					end
				end
			end
			FSM_LOAD: begin
				we      = 1'b1;
				wdata   = {op_q.coord_x, op_q.coord_y};
				state_d = FSM_P_RD;
			end
			FSM_P_RD:  state_d = FSM_P_DAT;
			FSM_P_DAT: begin
				if (idx_q == '0) begin
					state_d = (n_w < CNT_W'(2)) ? FSM_P_END : FSM_P_RD;
				end else begin
					state_d = FSM_P_SQ;
				end
			end
			FSM_P_SQ: state_d = FSM_P_RT;
			FSM_P_RT: begin
				if (bit_cnt_q == '0) begin
					state_d = last_edge ? FSM_P_END : FSM_P_RD;
				end
			end
			FSM_P_END: begin
				if (res_status_q == STAT_INVALID || res_status_q == STAT_LOADED) begin
					state_d = FSM_OUT;
				end else if (!pass_q) begin
					state_d = FSM_SW_RA;
				end else if (grew) begin
					state_d = FSM_UN_A;
				end else begin
					state_d = FSM_OUT;
				end
			end
			FSM_SW_RA: begin
				raddr   = op_q.first_city;
				state_d = FSM_SW_RB;
			end
			FSM_SW_RB: begin
				raddr   = op_q.second_city;
				state_d = FSM_SW_WA;
			end
			FSM_SW_WA: begin
				we      = 1'b1;
				waddr   = op_q.first_city;
				wdata   = rdata_q;
				state_d = FSM_SW_WB;
			end
			FSM_SW_WB: begin
				we      = 1'b1;
				waddr   = op_q.second_city;
				wdata   = ent_a_q;
				state_d = FSM_P_RD;
			end
			FSM_UN_A: begin
				we      = 1'b1;
				waddr   = op_q.first_city;
				wdata   = ent_a_q;
				state_d = FSM_UN_B;
			end
			FSM_UN_B: begin
				we      = 1'b1;
				waddr   = op_q.second_city;
				wdata   = ent_b_q;
				state_d = FSM_OUT;
			end
			FSM_OUT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			FSM_IDLE: begin
				op_q   <= in_data;
				idx_q  <= '0;
				sum_q  <= '0;
				pass_q <= 1'b0;
				if (!in_data.mode) begin
					res_status_q <= STAT_LOADED;
				end else if (swap_ok) begin
					res_status_q <= STAT_KEPT;
				end else begin
					res_status_q <= STAT_INVALID;
				end
			end
			FSM_P_DAT: begin
				prev_q <= rdata_q;
				if (idx_q == '0) begin
					idx_q <= IDX_W'(1);
				end else begin
					dx_q <= diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
					dy_q <= diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
				end
			end
			FSM_P_SQ: begin
				rad_q     <= {(RAD_W-SQ_W-16)'(0), sq_sum, 16'b0};
				rem_q     <= '0;
				root_q    <= '0;
				bit_cnt_q <= 5'(ROOT_W - 1);
			end
			FSM_P_RT: begin
				rad_q     <= {rad_q[RAD_W-3:0], 2'b00};
				rem_q     <= rem_n;
				root_q    <= root_n;
				bit_cnt_q <= bit_cnt_q - 5'd1;
				if (bit_cnt_q == '0) begin
					sum_q <= sum_q + SUM_W'(root_n);
					if (!last_edge) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
			end
			FSM_P_END: begin
				res_sum_q <= sum_q;
				if (res_status_q == STAT_KEPT && !pass_q) begin
					before_q <= sum_q;
				end
				if (res_status_q == STAT_KEPT && pass_q && grew) begin
					res_status_q <= STAT_UNDONE;
					res_sum_q    <= before_q;
				end
			end
			FSM_SW_RB: ent_a_q <= rdata_q;
			FSM_SW_WA: ent_b_q <= rdata_q;
			FSM_SW_WB: begin
				idx_q  <= '0;
				sum_q  <= '0;
				pass_q <= 1'b1;
			end
			FSM_OUT: begin
				if (!out_valid_q || !out_stall) begin
					out_q.status      <= res_status_q;
					out_q.path_length <= whole[SUM_W-9] ? {LEN_W{1'b1}} : whole[LEN_W-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= CNT_W'(CNT_RESET);
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			if (state_q == FSM_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/tshc_checker.sv]
// port-level checker for the tour swap hill climbing unit, bound to the top level
// depends on tshc_pkg and tour_swap_hill_climb_unit_assert.svh
`include "tour_swap_hill_climb_unit_assert.svh"

module tshc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input tshc_pkg::out_item_t out_data,
	input logic                cfg_ready
);
	import tshc_pkg::*;

	// a waiting result must not change
	`TSHC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
	// one item at a time: the input closes right after a transaction
	`TSHC_ASSERT_NEXT(a_in_closes, in_valid && !in_stall, in_stall, "input open after transaction")
	// when no result is waiting, none can appear in the cycle after an item is taken
	`TSHC_ASSERT_NEXT(a_no_instant, in_valid && !in_stall && !out_valid, !out_valid, "result without work")
	`TSHC_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "config port not ready")

endmodule

bind tour_swap_hill_climb_unit tshc_checker u_tshc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.cfg_ready (cfg_ready)
);

[bench/tb.sv]
// self-checking bench for tour_swap_hill_climb_unit: loads and swaps with a path-length predictor
// depends on tshc_pkg and the unit rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tshc_pkg::*;

	localparam int CYCLE_LIMIT = 10000000;

	typedef struct {
		int        cnt;   // city_count in force for the row
		in_item_t  item;
		bit        fixed; // expectation typed in below
		status_t   st;
		int        len;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;

	logic [9:0]  xs [MAX_CITIES];
	logic [9:0]  ys [MAX_CITIES];
	int          cur_count;
	out_item_t   pending_results [$];
	int          errors = 0;
	int          sent = 0;
	bit          quiet = 0;
	int          stall_left = 0;
	int          cycles = 0;
	row_t        rows [$];

	tour_swap_hill_climb_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int i = 18; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	// whole part of the open path over the active positions
	function automatic longint unsigned open_path_len();
		longint unsigned sum;
		longint dx, dy;
		int n;
		sum = 0;
		n = (cur_count < MAX_CITIES) ? cur_count : MAX_CITIES;
		for (int i = 1; i < n; i++) begin
			dx = longint'(xs[i]) - longint'(xs[i-1]);
			dy = longint'(ys[i]) - longint'(ys[i-1]);
			sum += int_sqrt((dx * dx + dy * dy) * 65536);
		end
		return sum >> 8;
	endfunction

	function automatic void swap_entries(int a, int b);
		logic [9:0] t;
		t = xs[a]; xs[a] = xs[b]; xs[b] = t;
		t = ys[a]; ys[a] = ys[b]; ys[b] = t;
	endfunction

	function automatic out_item_t predict_step(in_item_t it);
		out_item_t r;
		longint unsigned old_len, new_len;
		int n;
		int a, b;
		a = it.first_city;
		b = it.second_city;
		n = (cur_count < MAX_CITIES) ? cur_count : MAX_CITIES;
		if (!it.mode) begin
			xs[a] = it.coord_x;
			ys[a] = it.coord_y;
			r.status = STAT_LOADED;
		end else if (a == b || a >= n || b >= n) begin
			r.status = STAT_INVALID;
		end else begin
			old_len = open_path_len();
			swap_entries(a, b);
			new_len = open_path_len();
			if (new_len > old_len) begin
				swap_entries(a, b);
				r.status = STAT_UNDONE;
			end else begin
				r.status = STAT_KEPT;
			end
		end
		new_len = open_path_len();
		r.path_length = (new_len > 262143) ? 18'h3FFFF : new_len[LEN_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// result side stalls in random bursts
	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			if (stall_left == 0)
				out_stall <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(1, 16);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("tb: unexpected result %p", out_data);
			end else begin
				want = pending_results.pop_front();
				if (want.status !== out_data.status ||
						want.path_length !== out_data.path_length) begin
					errors++;
					if (errors <= 10)
						$display("tb: mismatch exp %s/%0d got %0d/%0d", want.status.name(),
							want.path_length, out_data.status, out_data.path_length);
				end
			end
		end
	end

	task automatic drain();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_count(int v);
		in_valid <= 1'b0;
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v[7:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_count = v;
	endtask

	// one input transaction, sometimes preceded by a random gap (never when quiet)
	task automatic send_item(in_item_t it, bit fixed, status_t st, int len);
		out_item_t r;
		if (!quiet && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		r = predict_step(it);
		if (fixed) begin
			r.status = st;
			r.path_length = len[LEN_W-1:0];
		end
		pending_results.push_back(r);
		sent++;
	endtask

	function automatic in_item_t mk(bit m, int a, int b, int x, int y);
		in_item_t it;
		it.mode = m;
		it.first_city = a[IDX_W-1:0];
		it.second_city = b[IDX_W-1:0];
		it.coord_x = x[9:0];
		it.coord_y = y[9:0];
		return it;
	endfunction

	function automatic void add_row(int c, in_item_t it, bit f, status_t st, int len);
		row_t r;
		r.cnt = c; r.item = it; r.fixed = f; r.st = st; r.len = len;
		rows.push_back(r);
	endfunction

	initial begin
		in_item_t it;
		int n, k, lim;
		cur_count = CNT_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count 0 first, so no pass reads an unwritten entry
		add_row(0, mk(0, 0, 0, 0, 0), 1, STAT_LOADED, 0);
		add_row(0, mk(0, 127, 127, 1023, 1023), 1, STAT_LOADED, 0);
		add_row(0, mk(0, 5, 0, 1023, 0), 1, STAT_LOADED, 0);
		add_row(0, mk(1, 0, 1, 0, 0), 1, STAT_INVALID, 0);
		add_row(0, mk(1, 3, 3, 1023, 1023), 1, STAT_INVALID, 0);
		for (int i = 0; i < MAX_CITIES; i++)
			add_row(1, mk(0, i, $urandom_range(0, 127), $urandom_range(0, 1023),
				$urandom_range(0, 1023)), 0, STAT_LOADED, 0);
		add_row(1, mk(1, 0, 1, 0, 0), 0, STAT_LOADED, 0);
		add_row(255, mk(1, 0, 127, 0, 0), 0, STAT_LOADED, 0);
		add_row(255, mk(1, 127, 127, 0, 0), 0, STAT_LOADED, 0);
		add_row(128, mk(1, 5, 6, 0, 0), 0, STAT_LOADED, 0);
		add_row(2, mk(1, 0, 1, 0, 0), 0, STAT_LOADED, 0);
		add_row(2, mk(1, 1, 0, 0, 0), 0, STAT_LOADED, 0);
		add_row(2, mk(1, 0, 2, 0, 0), 0, STAT_LOADED, 0);
		add_row(2, mk(0, 1, 0, 1023, 1023), 0, STAT_LOADED, 0);
		add_row(3, mk(1, 2, 0, 0, 0), 0, STAT_LOADED, 0);
		foreach (rows[i]) begin
			if (rows[i].cnt != cur_count)
				set_count(rows[i].cnt);
			send_item(rows[i].item, rows[i].fixed, rows[i].st, rows[i].len);
		end

		while (sent < 400) begin
			k = $urandom_range(0, 19);
			if (k == 0)       n = 255;
			else if (k == 1)  n = 128;
			else if (k == 2)  n = $urandom_range(0, 1);
			else if (k == 3)  n = $urandom_range(20, 60);
			else              n = $urandom_range(2, 12);
			in_valid <= 1'b0;
			set_count(n);
			lim = (n > 60) ? 3 : $urandom_range(10, 30);
			for (int j = 0; j < lim; j++) begin
				if (sent >= 360)
					quiet = 1;
				k = (n < 2) ? 2 : n;
				if ($urandom_range(0, 9) < 3)
					it = mk(0, $urandom_range(0, 127), $urandom_range(0, 127),
						$urandom_range(0, 1023), $urandom_range(0, 1023));
				else if ($urandom_range(0, 9) == 0)
					it = mk(1, $urandom_range(0, 127), $urandom_range(0, 127),
						$urandom_range(0, 1023), $urandom_range(0, 1023));
				else
					it = mk(1, $urandom_range(0, (k > 128 ? 128 : k) - 1),
						$urandom_range(0, (k > 128 ? 128 : k) - 1),
						$urandom_range(0, 1023), $urandom_range(0, 1023));
				send_item(it, 0, STAT_LOADED, 0);
			end
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
